// File: rtl/stfc_pkg.sv
`default_nettype none

package stfc_pkg;

    // Sample width default and fixed field widths
    localparam int DEF_SAMPLE_BITS = 10;
    localparam int VOLT_BITS       = 10;   // tenths of a volt, 0..550
    localparam int LEN_W           = 7;
    localparam int LIM_W           = 10;
    localparam int PWM_W           = 8;
    localparam int REM_W           = 6;
    localparam int TAP_W           = 2;

    // Configuration port
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    // Scaling constants
    localparam logic [VOLT_BITS-1:0] VOLT_SCALE = 10'd550;
    localparam logic [PWM_W-1:0]     PWM_TOP    = 8'd255;
    localparam logic [LEN_W-1:0]     MAX_LENGTH = 7'd64;

    // Register reset values
    localparam logic [LEN_W-1:0] RST_FILTER_LENGTH = 7'd10;
    localparam logic [LEN_W-1:0] RST_FILTER_WEIGHT = 7'd1;
    localparam logic [LIM_W-1:0] RST_STEP1_LIMIT   = 10'd120;
    localparam logic [LIM_W-1:0] RST_STEP2_LIMIT   = 10'd250;
    localparam logic [LIM_W-1:0] RST_HYSTERESIS    = 10'd10;
    localparam int               RST_TEMP_HOT      = 390;
    localparam int               RST_TEMP_COOL     = 490;
    localparam logic [PWM_W-1:0] RST_FAN_MIN       = 8'd15;

    // Register map, word index
    typedef enum logic [2:0] {
        REG_FILTER_LENGTH = 3'd0,
        REG_FILTER_WEIGHT = 3'd1,
        REG_STEP1_LIMIT   = 3'd2,
        REG_STEP2_LIMIT   = 3'd3,
        REG_HYSTERESIS    = 3'd4,
        REG_TEMP_HOT      = 3'd5,
        REG_TEMP_COOL     = 3'd6,
        REG_FAN_MIN       = 3'd7
    } t_reg_idx;

endpackage

`default_nettype wire

// File: rtl/stfc_if.sv
`default_nettype none

// Sample item channel
interface stfc_in_if
    import stfc_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) ();
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] voltage_sample;
    logic [SAMPLE_BITS-1:0] temp_sample;

    modport source (output valid, voltage_sample, temp_sample, input ready);
    modport sink   (input valid, voltage_sample, temp_sample, output ready);
endinterface

// Result item channel
interface stfc_out_if
    import stfc_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) ();
    logic                   valid;
    logic                   ready;
    logic [TAP_W-1:0]       tap_step;
    logic                   relay_one;
    logic                   relay_two;
    logic [PWM_W-1:0]       fan_pwm;
    logic [SAMPLE_BITS-1:0] filtered_temp;

    modport source (output valid, tap_step, relay_one, relay_two, fan_pwm, filtered_temp,
                    input ready);
    modport sink   (input valid, tap_step, relay_one, relay_two, fan_pwm, filtered_temp,
                    output ready);
endinterface

`default_nettype wire

// File: rtl/stfc_div.sv
`default_nettype none

// Restoring divider, two quotient bits per cycle.
// The caller guarantees dividend < divisor * 2**QW, so the upper part of the
// dividend already is a valid partial remainder.
module stfc_div #(
    parameter int DVS_W = 10,
    parameter int QW    = 10     // quotient bits, even
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [DVS_W+QW-1:0]   i_dividend,
    input  wire logic [DVS_W-1:0]      i_divisor,
    output logic                       o_busy,
    output logic [QW-1:0]              o_quotient,
    output logic [DVS_W-1:0]           o_remainder
);
    localparam int ITER = QW / 2;
    localparam int CW   = $clog2(ITER + 1);

    logic [DVS_W-1:0] r_rem;
    logic [QW-1:0]    r_low;
    logic [DVS_W-1:0] r_dvs;
    logic [CW-1:0]    r_cnt;

    logic [DVS_W:0]   s1;
    logic [DVS_W:0]   s2;

    // one compare-subtract step: {quotient bit, new remainder}
    function automatic logic [DVS_W:0] div_step(input logic [DVS_W-1:0] rem,
                                                input logic bit_in,
                                                input logic [DVS_W-1:0] dvs);
        logic [DVS_W:0] t;
        logic [DVS_W:0] d;
        t = {rem, bit_in};
        d = {1'b0, dvs};
        if (t >= d) begin
            div_step = {1'b1, DVS_W'(t - d)};
        end else begin
            div_step = {1'b0, t[DVS_W-1:0]};
        end
    endfunction

    always_comb begin
        s1 = div_step(r_rem, r_low[QW-1], r_dvs);
        s2 = div_step(s1[DVS_W-1:0], r_low[QW-2], r_dvs);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_rem <= i_dividend[DVS_W+QW-1:QW];
            r_low <= i_dividend[QW-1:0];
            r_dvs <= i_divisor;
            r_cnt <= CW'(ITER);
        end else if (r_cnt != '0) begin
            // shift dividend bits out at the top, quotient bits in at the bottom
            r_rem <= s2[DVS_W-1:0];
            r_low <= {r_low[QW-3:0], s1[DVS_W], s2[DVS_W]};
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_busy      = (r_cnt != '0);
    assign o_quotient  = r_low;
    assign o_remainder = r_rem;

endmodule

`default_nettype wire

// File: rtl/supply_tap_and_fan_controller_core.sv
`default_nettype none

// Supply tap selector and fan controller. Each item carries a raw voltage
// feedback sample and a raw temperature sample and yields one result: the
// transformer step (with hysteresis) and its two relay drives, the filtered
// temperature and the fan PWM value. A small microprogram steps a shared
// multiplier and a shared divider that retires two quotient bits a cycle;
// QW is the larger of SAMPLE_BITS and 10, rounded up to even. The voltage
// scaling divides by the full-scale code with two add-and-fold passes and
// one compare, in a single step. An item skips the fan divider pass when
// the filtered temperature is outside the fan's linear range. The next
// item is taken in the cycle after the result is written. One item is in
// work at a time; a finished result waits in the output register, and a
// new item is taken meanwhile. The first item primes the temperature
// filter. Registers sit on an APB port at byte address 4*index; the user
// must make writes only while no item is in work, as the block itself
// does not enforce this.
module supply_tap_and_fan_controller_core
    import stfc_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    stfc_in_if.sink                i_in,
    stfc_out_if.source             o_out,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready
);
    localparam int SB    = SAMPLE_BITS;
    localparam int QW    = (((SB > VOLT_BITS) ? SB : VOLT_BITS) + 1) / 2 * 2;
    localparam int ACC_W = SB + QW;
    localparam int PW    = SB + VOLT_BITS;
    localparam int UPC_W = 4;

    // Microprogram addresses
    localparam logic [UPC_W-1:0] US_VMUL   = 4'd0;
    localparam logic [UPC_W-1:0] US_VDIV   = 4'd1;
    localparam logic [UPC_W-1:0] US_AVGMUL = 4'd2;
    localparam logic [UPC_W-1:0] US_TAP    = 4'd3;
    localparam logic [UPC_W-1:0] US_AVGDIV = 4'd4;
    localparam logic [UPC_W-1:0] US_AVG    = 4'd5;
    localparam logic [UPC_W-1:0] US_FANCHK = 4'd6;
    localparam logic [UPC_W-1:0] US_FANDIV = 4'd7;
    localparam logic [UPC_W-1:0] US_FAN    = 4'd8;
    localparam logic [UPC_W-1:0] US_DONE   = 4'd9;

    typedef enum logic [2:0] {MUL_NONE, MUL_VOLT, MUL_PREV, MUL_AVG, MUL_FAN} t_mul_op;
    typedef enum logic [1:0] {DIV_NONE, DIV_LEN, DIV_FAN} t_div_op;
    typedef enum logic [2:0] {
        WB_NONE, WB_VOLT, WB_TAP, WB_AVG, WB_FANCHK, WB_FAN, WB_DONE
    } t_wb_op;

    typedef struct packed {
        t_mul_op          mul;
        t_div_op          div;
        t_wb_op           wb;
        logic             wait_div;
        logic             jmp_out;   // jump when fan is outside linear range
        logic [UPC_W-1:0] target;
    } t_uword;

    typedef enum logic {ST_IDLE, ST_RUN} t_state;
    typedef enum logic [TAP_W-1:0] {TAP_FIRST = 2'd0, TAP_SECOND = 2'd1, TAP_THIRD = 2'd2} t_tap;

    // Control store
    function automatic t_uword ucode(input logic [UPC_W-1:0] upc);
        t_uword w;
        w = '{mul: MUL_NONE, div: DIV_NONE, wb: WB_NONE, wait_div: 1'b0,
              jmp_out: 1'b0, target: US_DONE};
        unique case (upc)
            US_VMUL:   w.mul = MUL_VOLT;
            US_VDIV:   begin w.mul = MUL_PREV; w.wb = WB_VOLT; end
            US_AVGMUL: w.mul = MUL_AVG;
            US_TAP:    w.wb = WB_TAP;
            US_AVGDIV: w.div = DIV_LEN;
            US_AVG:    begin w.wait_div = 1'b1; w.wb = WB_AVG; end
            US_FANCHK: begin w.mul = MUL_FAN; w.wb = WB_FANCHK; w.jmp_out = 1'b1; end
            US_FANDIV: w.div = DIV_FAN;
            US_FAN:    begin w.wait_div = 1'b1; w.wb = WB_FAN; end
            US_DONE:   w.wb = WB_DONE;
            default:   w.wb = WB_DONE;
        endcase
        return w;
    endfunction

    // Configuration registers
    logic [LEN_W-1:0] r_len, r_wgt;
    logic [LIM_W-1:0] r_l1, r_l2, r_hys;
    logic [SB-1:0]    r_hot, r_cool;
    logic [PWM_W-1:0] r_fmin;

    // Sequencer and datapath state
    t_state           r_state;
    logic [UPC_W-1:0] r_upc;
    logic [SB-1:0]    r_vs, r_ts;
    logic [ACC_W-1:0] r_acc;
    logic [VOLT_BITS-1:0] r_volt;
    t_tap             r_tap;
    logic             r_primed;
    logic [SB-1:0]    r_avg, r_prev;
    logic [REM_W-1:0] r_rem;
    logic [PWM_W-1:0] r_fan;

    // Output register
    logic             r_out_valid;
    t_tap             r_o_tap;
    logic [PWM_W-1:0] r_o_fan;
    logic [SB-1:0]    r_o_filt;

    t_uword           uw;
    logic             stall;
    logic             advance;
    logic [LEN_W-1:0] eff_len, eff_wgt;
    logic [SB-1:0]    mul_a;
    logic [VOLT_BITS-1:0] mul_b;
    logic [PW-1:0]    prod;
    logic [ACC_W-1:0] n_acc;
    logic [QW:0]      vf_r0, vf_r1;
    logic [QW-1:0]    vf_q;
    logic             div_start, div_busy;
    logic [SB-1:0]    div_dvs;
    logic [QW-1:0]    div_q;
    logic [SB-1:0]    div_r;
    t_tap             n_tap;
    logic             fan_out;
    logic [PWM_W-1:0] fan_edge;
    logic [PWM_W-1:0] n_fan;
    logic [QW:0]      fan_sum;
    logic             cfg_wr;
    t_reg_idx         cfg_idx;

    // APB decode
    assign pready  = 1'b1;
    assign cfg_idx = t_reg_idx'(paddr[APB_AW-1:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_comb begin
        unique case (cfg_idx)
            REG_FILTER_LENGTH: prdata = APB_DW'(r_len);
            REG_FILTER_WEIGHT: prdata = APB_DW'(r_wgt);
            REG_STEP1_LIMIT:   prdata = APB_DW'(r_l1);
            REG_STEP2_LIMIT:   prdata = APB_DW'(r_l2);
            REG_HYSTERESIS:    prdata = APB_DW'(r_hys);
            REG_TEMP_HOT:      prdata = APB_DW'(r_hot);
            REG_TEMP_COOL:     prdata = APB_DW'(r_cool);
            REG_FAN_MIN:       prdata = APB_DW'(r_fmin);
        endcase
    end

    // Effective filter length and weight
    always_comb begin
        if (r_len == '0) begin
            eff_len = LEN_W'(1);
        end else if (r_len > MAX_LENGTH) begin
            eff_len = MAX_LENGTH;
        end else begin
            eff_len = r_len;
        end
        eff_wgt = (r_wgt > eff_len) ? eff_len : r_wgt;
    end

    // Control word and stall
    assign uw      = ucode(r_upc);
    assign stall   = (uw.wait_div && div_busy) ||
                     ((uw.wb == WB_DONE) && r_out_valid && !o_out.ready);
    assign advance = (r_state == ST_RUN) && !stall;

    // Shared multiplier operands
    always_comb begin
        unique case (uw.mul)
            MUL_VOLT: begin mul_a = r_vs;   mul_b = VOLT_SCALE; end
            MUL_PREV: begin mul_a = r_prev; mul_b = VOLT_BITS'(eff_wgt); end
            MUL_AVG:  begin mul_a = r_avg;  mul_b = VOLT_BITS'(eff_len - eff_wgt); end
            MUL_FAN:  begin mul_a = r_cool - r_avg; mul_b = VOLT_BITS'(PWM_TOP - r_fmin); end
            default:  begin mul_a = r_vs;   mul_b = VOLT_SCALE; end
        endcase
        prod = PW'(mul_a) * PW'(mul_b);
    end

    // Accumulator update
    always_comb begin
        unique case (uw.mul)
            MUL_PREV: n_acc = ACC_W'(prod) + ACC_W'(r_rem);
            MUL_AVG:  n_acc = r_acc + ACC_W'(prod);
            MUL_VOLT,
            MUL_FAN:  n_acc = ACC_W'(prod);
            default:  n_acc = r_acc;
        endcase
    end

    // Scaled voltage: divide the product by 2**SB - 1. Each fold moves the
    // part above SB bits down, since 2**SB leaves a remainder of one.
    always_comb begin
        vf_r0 = (QW+1)'(r_acc[SB-1:0]) + (QW+1)'(r_acc[ACC_W-1:SB]);
        vf_r1 = (QW+1)'(vf_r0[SB-1:0]) + (QW+1)'(vf_r0[QW:SB]);
        vf_q  = r_acc[ACC_W-1:SB] + QW'(vf_r0[QW:SB]) +
                QW'(vf_r1 >= (QW+1)'({SB{1'b1}}));
    end

    // Divisor select
    always_comb begin
        unique case (uw.div)
            DIV_LEN:  div_dvs = SB'(eff_len);
            DIV_FAN:  div_dvs = r_cool - r_hot;
            default:  div_dvs = '1;
        endcase
    end

    assign div_start = advance && (uw.div != DIV_NONE);

    stfc_div #(
        .DVS_W (SB),
        .QW    (QW)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (r_acc),
        .i_divisor   (div_dvs),
        .o_busy      (div_busy),
        .o_quotient  (div_q),
        .o_remainder (div_r)
    );

    // Tap selector with hysteresis; the voltage is in tenths of a volt
    always_comb begin
        logic [VOLT_BITS-1:0] v;
        logic [LIM_W:0]       vh;
        logic [LIM_W:0]       l1e;
        logic [LIM_W:0]       l2e;
        v     = r_volt;
        vh    = {1'b0, v} + {1'b0, r_hys};
        l1e   = {1'b0, r_l1};
        l2e   = {1'b0, r_l2};
        n_tap = r_tap;
        unique case (r_tap)
            TAP_FIRST: begin
                if (v > r_l1) begin
                    n_tap = (v <= r_l2) ? TAP_SECOND : TAP_THIRD;
                end
            end
            TAP_SECOND: begin
                if (v > r_l2) begin
                    n_tap = TAP_THIRD;
                end else if (vh <= l1e) begin
                    n_tap = TAP_FIRST;
                end
            end
            TAP_THIRD: begin
                if (vh <= l2e) begin
                    if (v > r_l1) begin
                        n_tap = TAP_SECOND;
                    end else if (vh <= l1e) begin
                        n_tap = TAP_FIRST;
                    end
                end
            end
            default: n_tap = r_tap;
        endcase
    end

    // Fan: ends of the range, then the linear value with clamp
    always_comb begin
        fan_out  = (r_avg >= r_cool) || (r_avg <= r_hot);
        fan_edge = (r_avg >= r_cool) ? '0 : PWM_TOP;
        fan_sum  = {1'b0, div_q} + (QW+1)'(r_fmin);
        n_fan    = (fan_sum > (QW+1)'(PWM_TOP)) ? PWM_TOP : fan_sum[PWM_W-1:0];
    end

    // Sequencer, datapath registers, configuration and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_upc       <= US_VMUL;
            r_out_valid <= 1'b0;
            r_tap       <= TAP_FIRST;
            r_primed    <= 1'b0;
            r_avg       <= '0;
            r_prev      <= '0;
            r_rem       <= '0;
            r_len       <= RST_FILTER_LENGTH;
            r_wgt       <= RST_FILTER_WEIGHT;
            r_l1        <= RST_STEP1_LIMIT;
            r_l2        <= RST_STEP2_LIMIT;
            r_hys       <= RST_HYSTERESIS;
            r_hot       <= SB'(RST_TEMP_HOT);
            r_cool      <= SB'(RST_TEMP_COOL);
            r_fmin      <= RST_FAN_MIN;
        end else begin
            // register writes
            if (cfg_wr) begin
                unique case (cfg_idx)
                    REG_FILTER_LENGTH: r_len  <= pwdata[LEN_W-1:0];
                    REG_FILTER_WEIGHT: r_wgt  <= pwdata[LEN_W-1:0];
                    REG_STEP1_LIMIT:   r_l1   <= pwdata[LIM_W-1:0];
                    REG_STEP2_LIMIT:   r_l2   <= pwdata[LIM_W-1:0];
                    REG_HYSTERESIS:    r_hys  <= pwdata[LIM_W-1:0];
                    REG_TEMP_HOT:      r_hot  <= pwdata[SB-1:0];
                    REG_TEMP_COOL:     r_cool <= pwdata[SB-1:0];
                    REG_FAN_MIN:       r_fmin <= pwdata[PWM_W-1:0];
                endcase
            end

            // result taken downstream, unless a new one lands in the same cycle
            if (r_out_valid && o_out.ready && !(advance && (uw.wb == WB_DONE))) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (i_in.valid) begin
                        r_vs    <= i_in.voltage_sample;
                        r_ts    <= i_in.temp_sample;
                        r_upc   <= US_VMUL;
                        r_state <= ST_RUN;
                        // first item primes the filter with its own sample
                        if (!r_primed) begin
                            r_avg    <= i_in.temp_sample;
                            r_prev   <= i_in.temp_sample;
                            r_rem    <= '0;
                            r_primed <= 1'b1;
                        end
                    end
                end
                ST_RUN: begin
                    if (!stall) begin
                        r_acc <= n_acc;
                        unique case (uw.wb)
                            WB_VOLT: r_volt <= vf_q[VOLT_BITS-1:0];
                            WB_TAP: r_tap <= n_tap;
                            WB_AVG: begin
                                r_avg  <= div_q[SB-1:0];
                                r_rem  <= div_r[REM_W-1:0];
                                r_prev <= r_ts;
                            end
                            WB_FANCHK: begin
                                if (fan_out) begin
                                    r_fan <= fan_edge;
                                end
                            end
                            WB_FAN: r_fan <= n_fan;
                            WB_DONE: begin
                                r_out_valid <= 1'b1;
                                r_o_tap     <= r_tap;
                                r_o_fan     <= r_fan;
                                r_o_filt    <= r_avg;
                                r_state     <= ST_IDLE;
                            end
                            default: ;
                        endcase
                        r_upc <= (uw.jmp_out && fan_out) ? uw.target : r_upc + 1'b1;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Ports
    assign i_in.ready          = (r_state == ST_IDLE);
    assign o_out.valid         = r_out_valid;
    assign o_out.tap_step      = r_o_tap;
    assign o_out.relay_one     = (r_o_tap != TAP_FIRST);
    assign o_out.relay_two     = (r_o_tap == TAP_THIRD);
    assign o_out.fan_pwm       = r_o_fan;
    assign o_out.filtered_temp = r_o_filt;

endmodule

`default_nettype wire
